[rtl/bpft_pkg.sv]
// Shared types and constants of the backup path failure tracker.
`timescale 1ns / 1ps

package bpft_pkg;

    localparam int DEF_MAX_LINKS      = 64;
    localparam int DEF_MAX_COMPONENTS = 64;
    localparam int DEF_TIME_BITS      = 32;

    localparam int MASK_W    = 64;
    localparam int AMOUNT_W  = 32;
    localparam int TRAFFIC_W = 40;
    localparam int SUM_W     = 64;
    localparam int COUNT_W   = 7;
    localparam int INDEX_W   = 6;
    localparam int KIND_W    = 3;
    localparam int STATE_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] REQ_LOAD_LINK = 3'd0;
    localparam logic [KIND_W-1:0] REQ_LOAD_COMP = 3'd1;
    localparam logic [KIND_W-1:0] REQ_START     = 3'd2;
    localparam logic [KIND_W-1:0] REQ_EVENT     = 3'd3;
    localparam logic [KIND_W-1:0] REQ_READ      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SQUARED    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP_COUNT = 2'd2;

    localparam logic [STATE_W-1:0] LS_PRIMARY = 2'd0;
    localparam logic [STATE_W-1:0] LS_BACKUP  = 2'd1;
    localparam logic [STATE_W-1:0] LS_FAILED  = 2'd2;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_ADD,
        ACT_SUB
    } act_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LINK_RD,
        ST_LINK_WAIT,
        ST_CHK_RD,
        ST_CHK_EVAL,
        ST_DECIDE,
        ST_RESV_RD,
        ST_RESV_WR,
        ST_MUL,
        ST_LINK_WR,
        ST_READ_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic cap;
        logic load_link;
        logic load_comp;
        logic start_clr;
        logic link_clr;
        logic link_inc;
        logic link_rd;
        logic link_wr;
        logic comp_clr;
        logic comp_inc;
        logic comp_rd;
        logic chk_clr;
        logic chk_eval;
        logic decide;
        logic resv_wr;
        logic mul;
        logic rd_out;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              link_done;
        logic              comp_done;
        logic              need_chk;
        logic              act_none;
    } sts_t;

endpackage

[rtl/bpft_ctrl.sv]
// Sequencer for load, start, event and read items.
`timescale 1ns / 1ps

module bpft_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output bpft_pkg::cmd_t cmd,
    input  bpft_pkg::sts_t sts
);
    import bpft_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Advance sequence
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = ST_DISPATCH;
            ST_DISPATCH:
                case (sts.kind)
                    REQ_EVENT: state_next = ST_LINK_RD;
                    REQ_READ:  state_next = ST_READ_OUT;
                    default:   state_next = ST_IDLE;
                endcase
            ST_LINK_RD:
                state_next = sts.link_done ? ST_IDLE : ST_LINK_WAIT;
            ST_LINK_WAIT:
                state_next = sts.need_chk ? ST_CHK_RD : ST_DECIDE;
            ST_CHK_RD:
                state_next = sts.comp_done ? ST_DECIDE : ST_CHK_EVAL;
            ST_CHK_EVAL:
                state_next = ST_CHK_RD;
            ST_DECIDE:
                state_next = ST_RESV_RD;
            ST_RESV_RD:
                state_next = (sts.comp_done || sts.act_none) ? ST_MUL : ST_RESV_WR;
            ST_RESV_WR:
                state_next = ST_RESV_RD;
            ST_MUL:
                state_next = ST_LINK_WR;
            ST_LINK_WR:
                state_next = ST_LINK_RD;
            ST_READ_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Drive commands
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
                cmd.cap = start;
            ST_DISPATCH:
            begin
                case (sts.kind)
                    REQ_LOAD_LINK: cmd.load_link = 1'b1;
                    REQ_LOAD_COMP: cmd.load_comp = 1'b1;
                    REQ_START:     cmd.start_clr = 1'b1;
                    REQ_EVENT:     cmd.link_clr  = 1'b1;
                    REQ_READ:      cmd.link_rd   = 1'b1;
                    default:       cmd.cap       = 1'b0;
                endcase
            end
            ST_LINK_RD:
                cmd.link_rd = !sts.link_done;
            ST_LINK_WAIT:
            begin
                cmd.comp_clr = 1'b1;
                cmd.chk_clr  = 1'b1;
            end
            ST_CHK_RD:
                cmd.comp_rd = !sts.comp_done;
            ST_CHK_EVAL:
            begin
                cmd.chk_eval = 1'b1;
                cmd.comp_inc = 1'b1;
            end
            ST_DECIDE:
            begin
                cmd.decide   = 1'b1;
                cmd.comp_clr = 1'b1;
            end
            ST_RESV_RD:
                cmd.comp_rd = !(sts.comp_done || sts.act_none);
            ST_RESV_WR:
            begin
                cmd.resv_wr  = 1'b1;
                cmd.comp_inc = 1'b1;
            end
            ST_MUL:
                cmd.mul = 1'b1;
            ST_LINK_WR:
            begin
                cmd.link_wr  = 1'b1;
                cmd.link_inc = 1'b1;
            end
            ST_READ_OUT:
                cmd.rd_out = 1'b1;
            default:
                cmd = '0;
        endcase
    end

endmodule

[rtl/bpft_datapath.sv]
// Tables, reservation store, outage arithmetic and result registers.
`timescale 1ns / 1ps

module bpft_datapath #(
    parameter int MAX_LINKS      = bpft_pkg::DEF_MAX_LINKS,
    parameter int MAX_COMPONENTS = bpft_pkg::DEF_MAX_COMPONENTS,
    parameter int TIME_BITS      = bpft_pkg::DEF_TIME_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bpft_pkg::cmd_t                      cmd,
    output bpft_pkg::sts_t                      sts,
    input  logic                                cfg_valid,
    input  logic [bpft_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpft_pkg::COUNT_W-1:0]        cfg_data,
    input  logic [bpft_pkg::KIND_W-1:0]         req_type,
    input  logic [bpft_pkg::INDEX_W-1:0]        entry_index,
    input  logic [bpft_pkg::MASK_W-1:0]         primary_mask,
    input  logic [bpft_pkg::MASK_W-1:0]         backup_mask,
    input  logic [bpft_pkg::AMOUNT_W-1:0]       amount,
    input  logic [bpft_pkg::MASK_W-1:0]         fail_mask,
    input  logic [31:0]                         event_time,
    output logic                                result_valid,
    output logic [bpft_pkg::INDEX_W-1:0]        read_index,
    output logic [bpft_pkg::SUM_W-1:0]          outage_total,
    output logic [bpft_pkg::STATE_W-1:0]        link_state
);
    import bpft_pkg::*;

    localparam int LAW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int LCW = $clog2(MAX_LINKS + 1);
    localparam int CAW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

    // Configuration registers
    logic               sq_reg;
    logic [COUNT_W-1:0] lcount_reg;
    logic [COUNT_W-1:0] ccount_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg     <= 1'b0;
            lcount_reg <= COUNT_W'(64);
            ccount_reg <= COUNT_W'(64);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SQUARED:    sq_reg     <= cfg_data[0];
                CFG_LINK_COUNT: lcount_reg <= cfg_data;
                CFG_COMP_COUNT: ccount_reg <= cfg_data;
                default:        sq_reg     <= sq_reg;
            endcase
        end
    end

    // Latched item
    logic [KIND_W-1:0]    kind_reg;
    logic [INDEX_W-1:0]   idx_reg;
    logic [MASK_W-1:0]    pri_in_reg;
    logic [MASK_W-1:0]    bak_in_reg;
    logic [AMOUNT_W-1:0]  amt_reg;
    logic [MASK_W-1:0]    fail_reg;
    logic [TIME_BITS-1:0] time_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            kind_reg   <= req_type;
            idx_reg    <= entry_index;
            pri_in_reg <= primary_mask;
            bak_in_reg <= backup_mask;
            amt_reg    <= amount;
            fail_reg   <= fail_mask;
            time_reg   <= event_time[TIME_BITS-1:0];
        end
    end

    // Counters and walk limits
    logic [LCW-1:0]     lcnt_reg;
    logic [COUNT_W-1:0] ccnt_reg;
    logic [LCW-1:0]     nlink;
    logic [COUNT_W-1:0] ncomp;

    assign nlink = (int'(lcount_reg) > MAX_LINKS) ? LCW'(MAX_LINKS) : LCW'(lcount_reg);
    assign ncomp = (int'(ccount_reg) > MAX_COMPONENTS) ? COUNT_W'(MAX_COMPONENTS) : ccount_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcnt_reg <= '0;
            ccnt_reg <= '0;
        end
        else
        begin
            if (cmd.link_clr)
                lcnt_reg <= '0;
            else if (cmd.link_inc)
                lcnt_reg <= lcnt_reg + LCW'(1);
            if (cmd.comp_clr)
                ccnt_reg <= '0;
            else if (cmd.comp_inc)
                ccnt_reg <= ccnt_reg + COUNT_W'(1);
        end
    end

    // Addresses
    logic [7:0]     idx_ext;
    logic           idx_in_links;
    logic           idx_in_comps;
    logic [LAW-1:0] laddr;
    logic [CAW-1:0] caddr;

    assign idx_ext      = {2'b00, idx_reg};
    assign idx_in_links = int'(idx_reg) < MAX_LINKS;
    assign idx_in_comps = int'(idx_reg) < MAX_COMPONENTS;
    assign laddr        = (kind_reg == REQ_EVENT) ? lcnt_reg[LAW-1:0] : idx_ext[LAW-1:0];
    assign caddr        = (kind_reg == REQ_LOAD_COMP) ? idx_ext[CAW-1:0] : ccnt_reg[CAW-1:0];

    // Per-connection memories
    logic [MASK_W-1:0]    pri_mem  [MAX_LINKS];
    logic [MASK_W-1:0]    bak_mem  [MAX_LINKS];
    logic [AMOUNT_W-1:0]  dem_mem  [MAX_LINKS];
    logic [TIME_BITS-1:0] ost_mem  [MAX_LINKS];
    logic [SUM_W-1:0]     sum_mem  [MAX_LINKS];
    logic [STATE_W-1:0]   st_mem   [MAX_LINKS];
    logic [MAX_LINKS-1:0] lvld_reg;

    logic [MASK_W-1:0]    pri_q;
    logic [MASK_W-1:0]    bak_q;
    logic [AMOUNT_W-1:0]  dem_q;
    logic [TIME_BITS-1:0] ost_q;
    logic [SUM_W-1:0]     sum_q;
    logic [STATE_W-1:0]   st_q;

    // Decision and outage registers
    logic [STATE_W-1:0] nxt_reg;
    act_t               act_reg;
    logic [SUM_W-1:0]   add_reg;
    logic               over_reg;

    logic [TIME_BITS-1:0]   dur;
    logic [2*TIME_BITS-1:0] prod;
    logic [SUM_W:0]         sum_wide;
    logic [SUM_W-1:0]       sum_sat;

    assign dur      = time_reg - ost_q;
    assign prod     = dur * dur;
    assign sum_wide = {1'b0, sum_q} + {1'b0, add_reg};
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    // Load, read and update connection entries
    always_ff @(posedge clk)
    begin
        if (cmd.load_link && idx_in_links)
        begin
            pri_mem[laddr] <= pri_in_reg;
            bak_mem[laddr] <= bak_in_reg;
            dem_mem[laddr] <= amt_reg;
        end
        if (cmd.link_wr)
        begin
            st_mem[laddr] <= nxt_reg;
            if (nxt_reg != st_q && nxt_reg == LS_FAILED)
                ost_mem[laddr] <= time_reg;
            if (nxt_reg != st_q && st_q == LS_FAILED)
                sum_mem[laddr] <= sum_sat;
            else
                sum_mem[laddr] <= sum_q;
        end
        if (cmd.link_rd)
        begin
            pri_q <= pri_mem[laddr];
            bak_q <= bak_mem[laddr];
            dem_q <= dem_mem[laddr];
            ost_q <= ost_mem[laddr];
            sum_q <= lvld_reg[laddr] ? sum_mem[laddr] : '0;
            st_q  <= lvld_reg[laddr] ? st_mem[laddr] : LS_PRIMARY;
        end
    end

    // Track written connection entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lvld_reg <= '0;
        else if (cmd.start_clr)
            lvld_reg <= '0;
        else if (cmd.link_wr)
            lvld_reg[laddr] <= 1'b1;
    end

    // Per-component memories
    logic [AMOUNT_W-1:0]       lim_mem [MAX_COMPONENTS];
    logic [TRAFFIC_W-1:0]      rsv_mem [MAX_COMPONENTS];
    logic [MAX_COMPONENTS-1:0] cvld_reg;
    logic [AMOUNT_W-1:0]       lim_q;
    logic [TRAFFIC_W-1:0]      rsv_q;

    logic [TRAFFIC_W:0]   rsv_plus;
    logic [TRAFFIC_W-1:0] rsv_new;
    logic                 bit_hit;

    assign bit_hit  = bak_q[ccnt_reg[INDEX_W-1:0]];
    assign rsv_plus = {1'b0, rsv_q} + (TRAFFIC_W + 1)'(dem_q);

    always_comb
    begin
        if (act_reg == ACT_ADD)
            rsv_new = rsv_plus[TRAFFIC_W] ? {TRAFFIC_W{1'b1}} : rsv_plus[TRAFFIC_W-1:0];
        else
            rsv_new = (rsv_q > TRAFFIC_W'(dem_q)) ? rsv_q - TRAFFIC_W'(dem_q) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_comp && idx_in_comps)
            lim_mem[caddr] <= amt_reg;
        if (cmd.resv_wr && bit_hit)
            rsv_mem[caddr] <= rsv_new;
        if (cmd.comp_rd)
        begin
            lim_q <= lim_mem[caddr];
            rsv_q <= cvld_reg[caddr] ? rsv_mem[caddr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cvld_reg <= '0;
        else if (cmd.start_clr)
            cvld_reg <= '0;
        else if (cmd.resv_wr && bit_hit)
            cvld_reg[caddr] <= 1'b1;
    end

    // Capacity check across backup components
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            over_reg <= 1'b0;
        else if (cmd.chk_clr)
            over_reg <= 1'b0;
        else if (cmd.chk_eval && bit_hit && (rsv_plus > (TRAFFIC_W + 1)'(lim_q)))
            over_reg <= 1'b1;
    end

    // Path decision for the current connection
    logic               hit_p;
    logic               hit_b;
    logic [STATE_W-1:0] nxt_d;
    act_t               act_d;

    assign hit_p = |(fail_reg & pri_q);
    assign hit_b = |(fail_reg & bak_q);

    always_comb
    begin
        nxt_d = st_q;
        act_d = ACT_NONE;
        case (st_q)
            LS_PRIMARY:
                if (hit_p)
                begin
                    if (hit_b || over_reg)
                        nxt_d = LS_FAILED;
                    else
                    begin
                        nxt_d = LS_BACKUP;
                        act_d = ACT_ADD;
                    end
                end
            LS_BACKUP:
                if (!hit_p)
                begin
                    nxt_d = LS_PRIMARY;
                    act_d = ACT_SUB;
                end
                else if (hit_b)
                begin
                    nxt_d = LS_FAILED;
                    act_d = ACT_SUB;
                end
            default:
                if (!hit_p)
                    nxt_d = LS_PRIMARY;
                else if (!hit_b && !over_reg)
                begin
                    nxt_d = LS_BACKUP;
                    act_d = ACT_ADD;
                end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            nxt_reg <= nxt_d;
            act_reg <= act_d;
        end
        if (cmd.mul)
            add_reg <= sq_reg ? SUM_W'(prod) : SUM_W'(dur);
    end

    // Result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else
            result_valid <= cmd.rd_out;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_out)
        begin
            read_index   <= idx_reg;
            outage_total <= (idx_in_links && dem_q != '0) ? sum_q : '0;
            link_state   <= idx_in_links ? st_q : LS_PRIMARY;
        end
    end

    // Status
    assign sts.kind      = kind_reg;
    assign sts.link_done = (lcnt_reg == nlink);
    assign sts.comp_done = (ccnt_reg == ncomp);
    assign sts.need_chk  = hit_p && !hit_b && (st_q != LS_BACKUP);
    assign sts.act_none  = (act_reg == ACT_NONE);

endmodule

[rtl/backup_path_failure_tracker_top.sv]
// Top level of the backup path failure tracker.
`timescale 1ns / 1ps

// Items are taken with start while busy is low; one item is worked at a time.
// A read item puts its result on the result ports for one cycle under
// result_valid (the receiver cannot stall, so results are never held back).
// An event walks the connections one by one: each connection is read; when
// needed, a capacity check then reads its backup components in turn; the path
// is decided; when the connection reserves or releases backup traffic, each
// component is read then written; the outage term is formed and the entry
// written back. The single-port component store is read, then written, once
// per component. Configuration writes are accepted at any time (cfg_ready is
// always high) but must only be issued while busy is low.
module backup_path_failure_tracker_top #(
    parameter int MAX_LINKS      = bpft_pkg::DEF_MAX_LINKS,
    parameter int MAX_COMPONENTS = bpft_pkg::DEF_MAX_COMPONENTS,
    parameter int TIME_BITS      = bpft_pkg::DEF_TIME_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpft_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpft_pkg::COUNT_W-1:0]    cfg_data,
    input  logic [bpft_pkg::KIND_W-1:0]     req_type,
    input  logic [bpft_pkg::INDEX_W-1:0]    entry_index,
    input  logic [bpft_pkg::MASK_W-1:0]     primary_mask,
    input  logic [bpft_pkg::MASK_W-1:0]     backup_mask,
    input  logic [bpft_pkg::AMOUNT_W-1:0]   amount,
    input  logic [bpft_pkg::MASK_W-1:0]     fail_mask,
    input  logic [31:0]                     event_time,
    output logic                            result_valid,
    output logic [bpft_pkg::INDEX_W-1:0]    read_index,
    output logic [bpft_pkg::SUM_W-1:0]      outage_total,
    output logic [bpft_pkg::STATE_W-1:0]    link_state
);
    import bpft_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // Sequencer
    bpft_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    // Storage and arithmetic
    bpft_datapath #(
        .MAX_LINKS      (MAX_LINKS),
        .MAX_COMPONENTS (MAX_COMPONENTS),
        .TIME_BITS      (TIME_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .entry_index  (entry_index),
        .primary_mask (primary_mask),
        .backup_mask  (backup_mask),
        .amount       (amount),
        .fail_mask    (fail_mask),
        .event_time   (event_time),
        .result_valid (result_valid),
        .read_index   (read_index),
        .outage_total (outage_total),
        .link_state   (link_state)
    );

endmodule

[rtl/bpft_checker.sv]
// Port-level checks of the backup path failure tracker, bound to the top level.
`timescale 1ns / 1ps

module bpft_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_valid,
    input logic [1:0] link_state
);

    // An accepted item always occupies the block in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // A result follows work, so the block was busy the cycle before
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without preceding work");

    // Each read transfer yields a single-cycle result
    a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for two cycles");

    // Reported state is one of primary, backup or failed
    a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (link_state != 2'd3))
        else $error("invalid connection state reported");

endmodule

bind backup_path_failure_tracker_top bpft_checker u_bpft_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .link_state   (link_state)
);

[test/tb.sv]
// Self-checking testbench for the backup path failure tracker.
`timescale 1ns / 1ps

module tb;
    import bpft_pkg::*;

    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  NLINK       = DEF_MAX_LINKS;
    localparam int  NCOMP       = DEF_MAX_COMPONENTS;
    localparam logic [TRAFFIC_W-1:0] TRAFFIC_SAT = {TRAFFIC_W{1'b1}};

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [INDEX_W-1:0]  idx;
        logic [MASK_W-1:0]   pmask;
        logic [MASK_W-1:0]   bmask;
        logic [AMOUNT_W-1:0] amt;
        logic [MASK_W-1:0]   fmask;
        logic [31:0]         tstamp;
        bit                  fixed;   // expected read result given in the row
        logic [SUM_W-1:0]    fixed_total;
        logic [STATE_W-1:0]  fixed_state;
    } stim_row_t;

    typedef struct {
        logic [INDEX_W-1:0] idx;
        logic [SUM_W-1:0]   total;
        logic [STATE_W-1:0] lstate;
    } read_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [COUNT_W-1:0]    cfg_data;
    logic [KIND_W-1:0]     req_type;
    logic [INDEX_W-1:0]    entry_index;
    logic [MASK_W-1:0]     primary_mask;
    logic [MASK_W-1:0]     backup_mask;
    logic [AMOUNT_W-1:0]   amount;
    logic [MASK_W-1:0]     fail_mask;
    logic [31:0]           event_time;
    logic                  result_valid;
    logic [INDEX_W-1:0]    read_index;
    logic [SUM_W-1:0]      outage_total;
    logic [STATE_W-1:0]    link_state;

    backup_path_failure_tracker_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .entry_index  (entry_index),
        .primary_mask (primary_mask),
        .backup_mask  (backup_mask),
        .amount       (amount),
        .fail_mask    (fail_mask),
        .event_time   (event_time),
        .result_valid (result_valid),
        .read_index   (read_index),
        .outage_total (outage_total),
        .link_state   (link_state)
    );

    // Shadow copy of the tracker state
    logic [STATE_W-1:0]   sh_state  [NLINK];
    logic [31:0]          sh_ostart [NLINK];
    logic [SUM_W-1:0]     sh_osum   [NLINK];
    logic [TRAFFIC_W-1:0] sh_resv   [NCOMP];
    logic [MASK_W-1:0]    sh_prim   [NLINK];
    logic [MASK_W-1:0]    sh_back   [NLINK];
    logic [AMOUNT_W-1:0]  sh_demand [NLINK];
    logic [AMOUNT_W-1:0]  sh_limit  [NCOMP];
    logic                 sh_squared;
    logic [COUNT_W-1:0]   sh_links;
    logic [COUNT_W-1:0]   sh_comps;

    read_result_t pending_reads[$];
    int           mismatches;
    int           failures;
    int           cycles;
    bit           no_idle;
    logic [31:0]  clock_now;

    // Clock and cycle budget
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int comps_walked();
        return (sh_comps > NCOMP) ? NCOMP : int'(sh_comps);
    endfunction

    function automatic bit backup_overloaded(int j);
        bit          hit;
        logic [63:0] want;
        hit = 1'b0;
        for (int c = 0; c < comps_walked(); c++)
        begin
            want = 64'(sh_resv[c]) + 64'(sh_demand[j]);
            if (sh_back[j][c] && want > 64'(sh_limit[c]))
                hit = 1'b1;
        end
        return hit;
    endfunction

    task automatic adjust_backup(int j, bit add);
        logic [63:0] want;
        for (int c = 0; c < comps_walked(); c++)
        begin
            if (sh_back[j][c])
            begin
                if (add)
                begin
                    want = 64'(sh_resv[c]) + 64'(sh_demand[j]);
                    sh_resv[c] = (want > 64'(TRAFFIC_SAT)) ? TRAFFIC_SAT : want[TRAFFIC_W-1:0];
                end
                else
                    sh_resv[c] = (64'(sh_resv[c]) > 64'(sh_demand[j]))
                               ? sh_resv[c] - TRAFFIC_W'(sh_demand[j]) : '0;
            end
        end
    endtask

    // Walk the connections for one failure event
    task automatic walk_failure(logic [MASK_W-1:0] fmask, logic [31:0] now);
        int                 links;
        bit                 p;
        bit                 b;
        logic [STATE_W-1:0] prev;
        logic [STATE_W-1:0] nxt;
        logic [31:0]        dur;
        logic [63:0]        add;
        links = (sh_links > NLINK) ? NLINK : int'(sh_links);
        for (int j = 0; j < links; j++)
        begin
            p = |(fmask & sh_prim[j]);
            b = |(fmask & sh_back[j]);
            prev = sh_state[j];
            nxt = prev;
            if (prev == LS_PRIMARY)
            begin
                if (p)
                begin
                    if (b || backup_overloaded(j))
                        nxt = LS_FAILED;
                    else
                    begin
                        adjust_backup(j, 1'b1);
                        nxt = LS_BACKUP;
                    end
                end
            end
            else if (prev == LS_BACKUP)
            begin
                if (!p || b)
                begin
                    adjust_backup(j, 1'b0);
                    nxt = p ? LS_FAILED : LS_PRIMARY;
                end
            end
            else
            begin
                if (!p)
                    nxt = LS_PRIMARY;
                else if (!b && !backup_overloaded(j))
                begin
                    adjust_backup(j, 1'b1);
                    nxt = LS_BACKUP;
                end
            end
            if (nxt != prev && nxt == LS_FAILED)
                sh_ostart[j] = now;
            else if (nxt != prev && prev == LS_FAILED)
            begin
                dur = now - sh_ostart[j];
                add = sh_squared ? 64'(dur) * 64'(dur) : 64'(dur);
                sh_osum[j] = (sh_osum[j] > ~add) ? {SUM_W{1'b1}} : sh_osum[j] + add;
            end
            sh_state[j] = nxt;
        end
    endtask

    // Apply one accepted item to the shadow state; queue a read result
    task automatic track_item(stim_row_t r);
        read_result_t res;
        case (r.kind)
            REQ_LOAD_LINK:
            begin
                sh_prim[r.idx]   = r.pmask;
                sh_back[r.idx]   = r.bmask;
                sh_demand[r.idx] = r.amt;
            end
            REQ_LOAD_COMP: sh_limit[r.idx] = r.amt;
            REQ_START:
            begin
                for (int j = 0; j < NLINK; j++)
                begin
                    sh_state[j] = LS_PRIMARY;
                    sh_osum[j]  = '0;
                end
                for (int c = 0; c < NCOMP; c++)
                    sh_resv[c] = '0;
            end
            REQ_EVENT: walk_failure(r.fmask, r.tstamp);
            REQ_READ:
            begin
                res.idx = r.idx;
                if (r.fixed)
                begin
                    res.total  = r.fixed_total;
                    res.lstate = r.fixed_state;
                end
                else
                begin
                    res.total  = (sh_demand[r.idx] != 0) ? sh_osum[r.idx] : '0;
                    res.lstate = sh_state[r.idx];
                end
                pending_reads.push_back(res);
            end
            default: ;
        endcase
    endtask

    // Transfer one item, then hold off for a random gap
    task automatic send_item(stim_row_t r);
        int gap;
        req_type     <= r.kind;
        entry_index  <= r.idx;
        primary_mask <= r.pmask;
        backup_mask  <= r.bmask;
        amount       <= r.amt;
        fail_mask    <= r.fmask;
        event_time   <= r.tstamp;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        track_item(r);
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain all results and let the block go idle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_reads.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SQUARED:    sh_squared = val[0];
            CFG_LINK_COUNT: sh_links   = val;
            CFG_COMP_COUNT: sh_comps   = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Sparse mask over the low n components, now and then fully random
    function automatic logic [MASK_W-1:0] draw_mask(int n);
        logic [MASK_W-1:0] m;
        m = '0;
        if ($urandom_range(0, 15) == 0)
            return {$urandom, $urandom};
        repeat ($urandom_range(1, 3))
            m[$urandom_range(0, n - 1)] = 1'b1;
        return m;
    endfunction

    function automatic stim_row_t blank_row(logic [KIND_W-1:0] kind, int idx);
        stim_row_t r;
        r = '{kind: kind, idx: INDEX_W'(idx), pmask: '0, bmask: '0, amt: '0,
              fmask: '0, tstamp: '0, fixed: 1'b0, fixed_total: '0, fixed_state: '0};
        return r;
    endfunction

    function automatic stim_row_t random_row(int n, int event_weight);
        stim_row_t r;
        int        pick;
        r = blank_row(REQ_READ, $urandom_range(0, NLINK - 1));
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            r.kind  = REQ_LOAD_LINK;
            r.pmask = draw_mask(n);
            r.bmask = draw_mask(n);
            r.amt   = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
        end
        else if (pick < 12)
        begin
            r.kind = REQ_LOAD_COMP;
            r.amt  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(20, 300);
        end
        else if (pick < 14)
            r.kind = REQ_START;
        else if (pick < 16)
        begin
            r.kind  = KIND_W'($urandom_range(5, 7));
            r.pmask = {$urandom, $urandom};
            r.fmask = {$urandom, $urandom};
        end
        else if (pick < 16 + event_weight)
        begin
            r.kind  = REQ_EVENT;
            r.fmask = ($urandom_range(0, 3) == 0) ? '0 : draw_mask(n);
            if ($urandom_range(0, 9) == 0)
                clock_now = $urandom;
            else
                clock_now = clock_now + $urandom_range(1, 2000);
            r.tstamp = clock_now;
        end
        return r;
    endfunction

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_reads.size() == 0)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: index %0d total %0h state %0d",
                             read_index, outage_total, link_state);
            end
            else if (read_index !== pending_reads[0].idx
                     || outage_total !== pending_reads[0].total
                     || link_state !== pending_reads[0].lstate)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected index %0d total %0h state %0d, got %0d %0h %0d",
                             pending_reads[0].idx, pending_reads[0].total,
                             pending_reads[0].lstate, read_index, outage_total, link_state);
                void'(pending_reads.pop_front());
            end
            else
                void'(pending_reads.pop_front());
        end
    end

    // Directed rows, run once every table entry is loaded
    stim_row_t directed[$];

    task automatic build_directed();
        stim_row_t r;
        r = blank_row(REQ_READ, 0);
        r.fixed = 1'b1;
        directed.push_back(r);
        r = blank_row(REQ_READ, NLINK - 1);
        r.fixed = 1'b1;
        directed.push_back(r);
        for (int k = 5; k <= 7; k++)
        begin
            r = blank_row(KIND_W'(k), 0);
            r.fmask = '1;
            directed.push_back(r);
        end
        r = blank_row(REQ_LOAD_LINK, NLINK - 1);
        r.pmask = '1;
        r.bmask = '1;
        r.amt   = '1;
        directed.push_back(r);
        r = blank_row(REQ_LOAD_COMP, NCOMP - 1);
        directed.push_back(r);
        r = blank_row(REQ_LOAD_COMP, 0);
        r.amt = '1;
        directed.push_back(r);
        r = blank_row(REQ_EVENT, 0);
        directed.push_back(r);
        r = blank_row(REQ_EVENT, 0);
        r.fmask  = 64'h0000_0000_0000_0001;
        r.tstamp = 32'd100;
        directed.push_back(r);
        r = blank_row(REQ_READ, 1);
        directed.push_back(r);
        r = blank_row(REQ_EVENT, 0);
        r.fmask  = '1;
        r.tstamp = 32'hFFFF_FFF0;
        directed.push_back(r);
        r = blank_row(REQ_READ, NLINK - 1);
        r.fixed       = 1'b1;
        r.fixed_state = LS_FAILED;
        directed.push_back(r);
        // Outage began at time 100 and ends at 16: the duration wraps
        r = blank_row(REQ_EVENT, 0);
        r.tstamp = 32'h0000_0010;
        directed.push_back(r);
        r = blank_row(REQ_READ, NLINK - 1);
        r.fixed       = 1'b1;
        r.fixed_total = 64'h0000_0000_FFFF_FFAC;
        r.fixed_state = LS_PRIMARY;
        directed.push_back(r);
        r = blank_row(REQ_READ, 0);
        directed.push_back(r);
        r = blank_row(REQ_START, 0);
        directed.push_back(r);
        r = blank_row(REQ_READ, NLINK - 1);
        r.fixed = 1'b1;
        directed.push_back(r);
    endtask

    initial
    begin
        stim_row_t r;
        int        n;
        int        weight;
        int        count;
        cycles       = 0;
        mismatches   = 0;
        failures     = 0;
        no_idle      = 1'b0;
        clock_now    = 32'd1000;
        sh_squared   = 1'b0;
        sh_links     = COUNT_W'(NLINK);
        sh_comps     = COUNT_W'(NCOMP);
        for (int j = 0; j < NLINK; j++)
        begin
            sh_state[j]  = LS_PRIMARY;
            sh_osum[j]   = '0;
            sh_ostart[j] = '0;
        end
        for (int c = 0; c < NCOMP; c++)
            sh_resv[c] = '0;
        rst_n        = 1'b0;
        start        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        req_type     = '0;
        entry_index  = '0;
        primary_mask = '0;
        backup_mask  = '0;
        amount       = '0;
        fail_mask    = '0;
        event_time   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every table entry before any event or read
        for (int j = 0; j < NLINK; j++)
        begin
            r = blank_row(REQ_LOAD_LINK, j);
            r.pmask = draw_mask(8);
            r.bmask = draw_mask(8);
            r.amt   = (j % 9 == 4) ? '0 : AMOUNT_W'($urandom_range(1, 60));
            send_item(r);
        end
        for (int c = 0; c < NCOMP; c++)
        begin
            r = blank_row(REQ_LOAD_COMP, c);
            r.amt = $urandom_range(40, 200);
            send_item(r);
        end

        build_directed();
        foreach (directed[i])
            send_item(directed[i]);

        // Random phases over several register settings
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: begin n = 8;  weight = 40; count = 60;  end
                1: begin n = 4;  weight = 40; count = 60;  end
                2: begin n = 64; weight = 3;  count = 30;  end
                3: begin n = 8;  weight = 45; count = 60;  end
                4: begin n = 2;  weight = 45; count = 60;  end
                5: begin n = 16; weight = 40; count = 40;  end
                default: begin n = 8; weight = 40; count = 40; end
            endcase
            case (ph)
                0:
                begin
                    write_reg(CFG_SQUARED, 7'd0);
                    write_reg(CFG_LINK_COUNT, 7'd8);
                    write_reg(CFG_COMP_COUNT, 7'd8);
                end
                1:
                begin
                    write_reg(CFG_SQUARED, 7'd1);
                    write_reg(CFG_LINK_COUNT, 7'd16);
                    write_reg(CFG_COMP_COUNT, 7'd4);
                end
                2:
                begin
                    write_reg(CFG_LINK_COUNT, 7'd127);
                    write_reg(CFG_COMP_COUNT, 7'd127);
                end
                3:
                begin
                    write_reg(CFG_SQUARED, 7'd0);
                    write_reg(CFG_LINK_COUNT, 7'd1);
                    write_reg(CFG_COMP_COUNT, 7'd1);
                end
                4:
                begin
                    write_reg(CFG_LINK_COUNT, 7'd0);
                    write_reg(CFG_COMP_COUNT, 7'd0);
                end
                5:
                begin
                    write_reg(CFG_SQUARED, 7'd1);
                    write_reg(CFG_LINK_COUNT, 7'd12);
                    write_reg(CFG_COMP_COUNT, 7'd16);
                end
                default:
                begin
                    write_reg(CFG_SQUARED, 7'd0);
                    write_reg(CFG_LINK_COUNT, 7'd24);
                    write_reg(CFG_COMP_COUNT, 7'd8);
                end
            endcase
            for (int i = 0; i < count; i++)
            begin
                if (i % 25 == 0)
                    no_idle = ($urandom_range(0, 2) == 0);
                send_item(random_row(n, weight));
            end
        end

        // Drain and report
        drain();
        repeat (20) @(posedge clk);
        if (failures == 0 && pending_reads.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
rtl/bpft_pkg.sv
rtl/bpft_ctrl.sv
rtl/bpft_datapath.sv
rtl/backup_path_failure_tracker_top.sv
rtl/bpft_checker.sv
test/tb.sv
